// ----- sv/swt_pkg.sv -----
// Package for the sliding-window TWAP engine: operation codes, status codes,
// widths and the shared segment record type. No dependencies.
package swt_pkg;

    localparam int DefaultSegmentDepth = 64;
    localparam int TimeWidth    = 48;
    localparam int PriceWidth   = 48;
    localparam int WindowWidth  = 40;
    localparam int SumWidth     = 128;
    localparam int DivisorWidth = 64;
    localparam logic [WindowWidth-1:0] WindowReset = 40'd2000;

    typedef enum logic [2:0] {
        FUNC_ANCHOR = 3'd0,
        FUNC_TRADE  = 3'd1,
        FUNC_CLOSE  = 3'd2,
        FUNC_QUERY  = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_TIME = 2'd1,
        ST_IGNORED = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // One ring entry: start, end and price.
    typedef struct packed {
        logic [TimeWidth-1:0]  seg_from;
        logic [TimeWidth-1:0]  seg_end;
        logic [PriceWidth-1:0] seg_price;
    } seg_t;

    localparam int SegWidth = 2 * TimeWidth + PriceWidth;

    // Divider request and reply between the sequencer and the divide unit.
    // The divisor is wide enough for the time total of ring depths up to 32768 entries.
    typedef struct packed {
        logic                    start;
        logic [SumWidth-1:0]     dividend;
        logic [DivisorWidth-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [PriceWidth-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL,
        S_ADDSEG,
        S_EV_READ,
        S_EV_WAIT,
        S_EV_MUL,
        S_EV_APPLY,
        S_DIV,
        S_OUT
    } state_t;

endpackage

// ----- sv/swt_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module swt_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- sv/swt_div.sv -----
// Iterative 128-by-64-bit divider for a signed dividend and an unsigned
// divisor, one quotient bit per cycle, truncating toward zero. Depends on swt_pkg.
module swt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  swt_pkg::div_req_t req,
    output swt_pkg::div_rsp_t rsp
);
    import swt_pkg::*;

    logic [SumWidth-1:0]     num_reg, num_next;
    logic [DivisorWidth:0]   rem_reg, rem_next;
    logic [63:0]             quo_reg, quo_next;
    logic [DivisorWidth-1:0] den_reg, den_next;
    logic                    neg_reg, neg_next;
    logic [7:0]              cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DivisorWidth:0]   shifted;
    logic [63:0]             q_signed;

    // One restoring step per cycle over all 128 dividend bits.
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[DivisorWidth-1:0], num_reg[SumWidth-1]};
        if (req.start)
        begin
            neg_next  = req.dividend[SumWidth-1];
            num_next  = req.dividend[SumWidth-1] ? (~req.dividend + 1'b1) : req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
            cnt_next  = 8'd128;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[SumWidth-2:0], 1'b0};
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 8'd1;
            if (cnt_reg == 8'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    assign q_signed     = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_signed[PriceWidth-1:0];

endmodule

// ----- sv/swt_seq.sv -----
// Sequencer of the TWAP engine: decodes requests, adds segments to the ring
// memory, walks the ring for eviction and drives the divider. Depends on
// swt_pkg, swt_ram and swt_div.
module swt_seq #(
    parameter int SegmentDepth = swt_pkg::DefaultSegmentDepth
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [swt_pkg::WindowWidth-1:0] win_len,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [2:0]                     in_func,
    input  logic [swt_pkg::TimeWidth-1:0]  in_time,
    input  logic [swt_pkg::PriceWidth-1:0] in_price,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [swt_pkg::PriceWidth-1:0] out_avg,
    output logic                           out_avg_valid,
    output logic [1:0]                     out_status
);
    import swt_pkg::*;

    localparam int AddrWidth  = $clog2(SegmentDepth);
    localparam int CountWidth = $clog2(SegmentDepth + 1);
    localparam int TailWidth  = CountWidth + 1;
    localparam int TotWidth   = TimeWidth + AddrWidth + 1;
    localparam logic [1:0] MulLast = 2'd2;

    state_t state_reg, state_next;

    logic [2:0]            func_reg, func_next;
    logic [TimeWidth-1:0]  time_reg, time_next;
    logic [PriceWidth-1:0] price_reg, price_next;
    logic [AddrWidth-1:0]  head_reg, head_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [SumWidth-1:0]   sum_reg, sum_next;
    logic [TotWidth-1:0]   total_reg, total_next;
    logic                  anc_reg, anc_next;
    logic [PriceWidth-1:0] anc_price_reg, anc_price_next;
    logic [TimeWidth-1:0]  anc_time_reg, anc_time_next;
    logic [PriceWidth-1:0] avg_reg, avg_next;
    logic                  avgv_reg, avgv_next;
    logic [1:0]            status_reg, status_next;
    // Multiplier operands, step count and accumulated product.
    logic [PriceWidth-1:0] mp_reg, mp_next;
    logic [TimeWidth-1:0]  md_reg, md_next;
    logic [1:0]            mcnt_reg, mcnt_next;
    logic [SumWidth-1:0]   prod_reg, prod_next;
    logic [15:0]           mchunk;
    logic signed [64:0]    mpart;
    logic                  evict_reg, evict_next;
    logic                  trim_reg, trim_next;
    logic [TimeWidth-1:0]  trim_end_reg;

    logic                  wr_en;
    logic [AddrWidth-1:0]  wr_addr;
    seg_t                  wr_seg;
    seg_t                  rd_seg;
    logic [SegWidth-1:0]   rd_bits;
    logic [AddrWidth-1:0]  tail;
    logic [TailWidth-1:0]  tail_sum;
    logic [TailWidth-1:0]  tail_wrap;
    logic signed [TimeWidth+1:0] cutoff;
    logic signed [TimeWidth+1:0] s_end;
    logic signed [TimeWidth+1:0] s_start;
    div_req_t              dreq;
    div_rsp_t              drsp;

    swt_ram #(.Width(SegWidth), .Depth(SegmentDepth)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_seg),
        .rd_addr (head_reg),
        .rd_data (rd_bits)
    );
    assign rd_seg = rd_bits;

    swt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Slot after the newest entry, wrapped at the ring depth.
    assign tail_sum  = {1'b0, count_reg} + {{(TailWidth - AddrWidth){1'b0}}, head_reg};
    assign tail_wrap = (tail_sum >= TailWidth'(SegmentDepth))
                     ? tail_sum - TailWidth'(SegmentDepth) : tail_sum;
    assign tail      = tail_wrap[AddrWidth-1:0];

    assign cutoff  = $signed({2'b00, time_reg})
                   - $signed({{(TimeWidth+2-WindowWidth){1'b0}}, win_len});
    assign s_end   = $signed({2'b00, rd_seg.seg_end});
    assign s_start = $signed({2'b00, rd_seg.seg_from});

    // Signed price times one 16-bit duration slice, most significant first.
    always_comb
    begin
        case (mcnt_reg)
            2'd0:    mchunk = md_reg[47:32];
            2'd1:    mchunk = md_reg[31:16];
            default: mchunk = md_reg[15:0];
        endcase
    end
    assign mpart = $signed(mp_reg) * $signed({1'b0, mchunk});

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:     if (in_valid) state_next = S_DECODE;
            S_DECODE:
            begin
                case (func_reg)
                    FUNC_TRADE:
                        if (!anc_reg) state_next = S_OUT;
                        else if (time_reg > anc_time_reg && count_reg != CountWidth'(SegmentDepth))
                            state_next = S_MUL;
                        else state_next = S_EV_READ;
                    FUNC_CLOSE:
                        if (anc_reg && time_reg > anc_time_reg
                            && count_reg != CountWidth'(SegmentDepth))
                            state_next = S_MUL;
                        else state_next = S_OUT;
                    FUNC_QUERY: state_next = S_EV_READ;
                    default:    state_next = S_OUT;
                endcase
            end
            S_MUL:      state_next = (mcnt_reg == MulLast) ? S_ADDSEG : S_MUL;
            S_ADDSEG:   state_next = (func_reg == FUNC_TRADE) ? S_EV_READ : S_OUT;
            S_EV_READ:  state_next = (count_reg == '0) ? ((func_reg == FUNC_QUERY) ? S_DIV : S_OUT)
                                                       : S_EV_WAIT;
            S_EV_WAIT:
            begin
                if (s_end <= cutoff || s_start < cutoff) state_next = S_EV_MUL;
                else state_next = (func_reg == FUNC_QUERY) ? S_DIV : S_OUT;
            end
            S_EV_MUL:   state_next = (mcnt_reg == MulLast) ? S_EV_APPLY : S_EV_MUL;
            S_EV_APPLY:
            begin
                if (evict_reg) state_next = S_EV_READ;
                else state_next = (func_reg == FUNC_QUERY) ? S_DIV : S_OUT;
            end
            S_DIV:
            begin
                if (total_reg == '0) state_next = S_OUT;
                else if (drsp.done) state_next = S_OUT;
            end
            S_OUT:      if (out_ready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        func_next      = func_reg;
        time_next      = time_reg;
        price_next     = price_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        total_next     = total_reg;
        anc_next       = anc_reg;
        anc_price_next = anc_price_reg;
        anc_time_next  = anc_time_reg;
        avg_next       = avg_reg;
        avgv_next      = avgv_reg;
        status_next    = status_reg;
        mp_next        = mp_reg;
        md_next        = md_reg;
        mcnt_next      = mcnt_reg;
        prod_next      = prod_reg;
        evict_next     = evict_reg;
        trim_next      = trim_reg;
        wr_en          = 1'b0;
        wr_addr        = tail;
        wr_seg.seg_from  = anc_time_reg;
        wr_seg.seg_end   = time_reg;
        wr_seg.seg_price = anc_price_reg;
        dreq.start     = 1'b0;
        dreq.dividend  = sum_reg;
        dreq.divisor   = {{(DivisorWidth-TotWidth){1'b0}}, total_reg};
        case (state_reg)
            S_IDLE:
            begin
                func_next   = in_func;
                time_next   = in_time;
                price_next  = in_price;
                avg_next    = '0;
                avgv_next   = 1'b0;
                status_next = ST_OK;
            end
            S_DECODE:
            begin
                mp_next   = anc_price_reg;
                md_next   = time_reg - anc_time_reg;
                mcnt_next = '0;
                prod_next = '0;
                case (func_reg)
                    FUNC_ANCHOR:
                    begin
                        anc_next       = 1'b1;
                        anc_time_next  = time_reg;
                        anc_price_next = price_reg;
                    end
                    FUNC_TRADE:
                    begin
                        if (anc_reg && time_reg > anc_time_reg
                            && count_reg == CountWidth'(SegmentDepth))
                            status_next = ST_FULL;
                        if (!anc_reg || !(time_reg > anc_time_reg)
                            || count_reg == CountWidth'(SegmentDepth))
                        begin
                            anc_next       = 1'b1;
                            anc_time_next  = time_reg;
                            anc_price_next = price_reg;
                        end
                    end
                    FUNC_CLOSE:
                    begin
                        if (!anc_reg) status_next = ST_IGNORED;
                        else if (time_reg > anc_time_reg
                                 && count_reg == CountWidth'(SegmentDepth))
                            status_next = ST_FULL;
                    end
                    FUNC_CLEAR:
                    begin
                        head_next      = '0;
                        count_next     = '0;
                        sum_next       = '0;
                        total_next     = '0;
                        anc_next       = 1'b0;
                        anc_time_next  = '0;
                        anc_price_next = '0;
                    end
                    default: ;
                endcase
            end
            S_MUL, S_EV_MUL:
            begin
                // Shift-and-add over three slices of the duration.
                prod_next = {prod_reg[SumWidth-17:0], 16'd0}
                          + {{(SumWidth-65){mpart[64]}}, mpart};
                mcnt_next = mcnt_reg + 2'd1;
            end
            S_ADDSEG:
            begin
                wr_en      = 1'b1;
                sum_next   = sum_reg + prod_reg;
                total_next = total_reg + TotWidth'(md_reg);
                count_next = count_reg + 1'b1;
                if (func_reg == FUNC_TRADE)
                begin
                    anc_time_next  = time_reg;
                    anc_price_next = price_reg;
                end
            end
            S_EV_WAIT:
            begin
                mp_next    = rd_seg.seg_price;
                mcnt_next  = '0;
                prod_next  = '0;
                evict_next = (s_end <= cutoff);
                trim_next  = !(s_end <= cutoff) && (s_start < cutoff);
                if (s_end <= cutoff)
                    md_next = rd_seg.seg_end - rd_seg.seg_from;
                else
                    md_next = cutoff[TimeWidth-1:0] - rd_seg.seg_from;
            end
            S_EV_APPLY:
            begin
                sum_next   = sum_reg - prod_reg;
                total_next = total_reg - TotWidth'(md_reg);
                if (evict_reg)
                begin
                    head_next  = (head_reg == AddrWidth'(SegmentDepth - 1)) ? '0 : head_reg + 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    // Trim: rewrite the oldest entry to start at the cutoff.
                    wr_en            = trim_reg;
                    wr_addr          = head_reg;
                    wr_seg.seg_from  = cutoff[TimeWidth-1:0];
                    wr_seg.seg_end   = trim_end_reg;
                    wr_seg.seg_price = mp_reg;
                end
            end
            S_DIV:
            begin
                if (total_reg == '0)
                    status_next = ST_NO_TIME;
                else if (drsp.done)
                begin
                    avg_next  = drsp.quotient;
                    avgv_next = 1'b1;
                end
            end
            default: ;
        endcase
        if (state_reg == S_EV_READ && state_next == S_DIV && total_reg != '0)
            dreq.start = 1'b1;
        if (state_reg == S_EV_APPLY && state_next == S_DIV && total_next != '0)
        begin
            dreq.start    = 1'b1;
            dreq.dividend = sum_next;
            dreq.divisor  = {{(DivisorWidth-TotWidth){1'b0}}, total_next};
        end
        if (state_reg == S_EV_WAIT && state_next == S_DIV && total_reg != '0)
            dreq.start = 1'b1;
    end

    // The trim rewrite needs the segment end; keep it from the read word.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_EV_WAIT)
            trim_end_reg <= rd_seg.seg_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            sum_reg       <= '0;
            total_reg     <= '0;
            anc_reg       <= 1'b0;
            anc_price_reg <= '0;
            anc_time_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            sum_reg       <= sum_next;
            total_reg     <= total_next;
            anc_reg       <= anc_next;
            anc_price_reg <= anc_price_next;
            anc_time_reg  <= anc_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        time_reg   <= time_next;
        price_reg  <= price_next;
        avg_reg    <= avg_next;
        avgv_reg   <= avgv_next;
        status_reg <= status_next;
        mp_reg     <= mp_next;
        md_reg     <= md_next;
        mcnt_reg   <= mcnt_next;
        prod_reg   <= prod_next;
        evict_reg  <= evict_next;
        trim_reg   <= trim_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign out_avg       = avg_reg;
    assign out_avg_valid = avgv_reg;
    assign out_status    = status_reg;

endmodule

// ----- sv/sliding_window_twap.sv -----
// Top level of the sliding-window TWAP engine: ports, window register.
// Depends on swt_pkg and swt_seq (which uses swt_ram and swt_div).
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/tready   | tuser: func; tdata: time_ms, price
//  m_axis   | out | m_axis_tvalid/tready   | tdata: average_price;
//           |     |                        | tuser: average_valid, status
//  cfg      | in  | cfg_valid/cfg_ready    | cfg_data: window_ms
//
// One request at a time. Anchor, clear and ignored items pass through decode to
// output; a segment add runs the multiply and add states, each evicted or
// trimmed segment a read, multiply and apply pass through the ring memory,
// and a query also runs the bit-serial divider.
// Reset sets window_ms to 2000 and empties the ring. A stalled result holds
// the engine until m_axis_tready.
module sliding_window_twap #(
    parameter int SEGMENT_DEPTH = swt_pkg::DefaultSegmentDepth
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [2:0] func
    input  logic [2:0]   s_axis_tuser,
    // [47:0] time_ms, [95:48] price
    input  logic [95:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [47:0] average_price
    output logic [47:0]  m_axis_tdata,
    // [0] average_valid, [2:1] status
    output logic [2:0]   m_axis_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [swt_pkg::WindowWidth-1:0] cfg_data
);
    import swt_pkg::*;

    logic [WindowWidth-1:0] window_reg;
    logic [PriceWidth-1:0]  avg;
    logic                   avg_valid;
    logic [1:0]             status;

    // Window register.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_reg <= WindowReset;
        else if (cfg_valid)
            window_reg <= cfg_data;
    end

    swt_seq #(.SegmentDepth(SEGMENT_DEPTH)) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_len       (window_reg),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_func       (s_axis_tuser),
        .in_time       (s_axis_tdata[47:0]),
        .in_price      (s_axis_tdata[95:48]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_avg       (avg),
        .out_avg_valid (avg_valid),
        .out_status    (status)
    );

    assign m_axis_tdata = avg;
    assign m_axis_tuser = {status, avg_valid};

endmodule
